/* hw/rtl/merge_sort_engine_macros.svh */
// Assertion macros shared by the merge sort engine RTL.
`ifndef MERGE_SORT_ENGINE_MACROS_SVH
`define MERGE_SORT_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/mse_pkg.sv */
// Package with widths, microcode types and the control store of the merge sort engine.
`timescale 1ns / 1ps

package mse_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_ELEMS_DEF = 64;
  localparam int PC_W          = 4;

  // Datapath operation selected by the current control word.
  typedef enum logic [3:0] {
    OP_LOAD  = 4'd0,
    OP_START = 4'd1,
    OP_PASS  = 4'd2,
    OP_BLK   = 4'd3,
    OP_MRG   = 4'd4,
    OP_NEXTB = 4'd5,
    OP_PEND  = 4'd6,
    OP_OSET  = 4'd7,
    OP_OUT   = 4'd8
  } op_t;

  // Branch condition evaluated by the sequencer.
  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_ALWAYS   = 3'd1,
    C_LAST_IN  = 3'd2,
    C_SORTED   = 3'd3,
    C_BLK_END  = 3'd4,
    C_MORE_BLK = 3'd5,
    C_OUT_END  = 3'd6
  } cond_t;

  typedef struct packed {
    logic            in_ready;
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] tgt;
    logic            hold;
  } ctrl_t;

  typedef struct packed {
    logic last_in;
    logic sorted;
    logic blk_end;
    logic more_blk;
    logic out_end;
  } flags_t;

  // Program addresses.
  localparam logic [PC_W-1:0] PC_LOAD  = 4'd0;
  localparam logic [PC_W-1:0] PC_START = 4'd1;
  localparam logic [PC_W-1:0] PC_PASS  = 4'd2;
  localparam logic [PC_W-1:0] PC_BLK   = 4'd3;
  localparam logic [PC_W-1:0] PC_MRG   = 4'd4;
  localparam logic [PC_W-1:0] PC_NEXTB = 4'd5;
  localparam logic [PC_W-1:0] PC_PEND  = 4'd6;
  localparam logic [PC_W-1:0] PC_OSET  = 4'd7;
  localparam logic [PC_W-1:0] PC_OUT   = 4'd8;

  // Control store. A true condition jumps to tgt; otherwise hold stays on the
  // step and a clear hold falls through to the next step.
  function automatic ctrl_t mse_ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      PC_LOAD: begin
        w = '{in_ready: 1'b1, op: OP_LOAD, cond: C_LAST_IN, tgt: PC_START, hold: 1'b1};
      end
      PC_START: begin
        w = '{in_ready: 1'b0, op: OP_START, cond: C_NEVER, tgt: PC_LOAD, hold: 1'b0};
      end
      PC_PASS: begin
        w = '{in_ready: 1'b0, op: OP_PASS, cond: C_SORTED, tgt: PC_OSET, hold: 1'b0};
      end
      PC_BLK: begin
        w = '{in_ready: 1'b0, op: OP_BLK, cond: C_NEVER, tgt: PC_LOAD, hold: 1'b0};
      end
      PC_MRG: begin
        w = '{in_ready: 1'b0, op: OP_MRG, cond: C_BLK_END, tgt: PC_NEXTB, hold: 1'b1};
      end
      PC_NEXTB: begin
        w = '{in_ready: 1'b0, op: OP_NEXTB, cond: C_MORE_BLK, tgt: PC_BLK, hold: 1'b0};
      end
      PC_PEND: begin
        w = '{in_ready: 1'b0, op: OP_PEND, cond: C_ALWAYS, tgt: PC_PASS, hold: 1'b0};
      end
      PC_OSET: begin
        w = '{in_ready: 1'b0, op: OP_OSET, cond: C_NEVER, tgt: PC_LOAD, hold: 1'b0};
      end
      PC_OUT: begin
        w = '{in_ready: 1'b0, op: OP_OUT, cond: C_OUT_END, tgt: PC_LOAD, hold: 1'b1};
      end
      default: begin
        w = '{in_ready: 1'b0, op: OP_OSET, cond: C_ALWAYS, tgt: PC_LOAD, hold: 1'b0};
      end
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/mse_in_if.sv */
// Interface of the input channel: one unsorted word per handshake.
`timescale 1ns / 1ps

interface mse_in_if import mse_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink (input valid, input value, input is_last, output ready);
endinterface

/* hw/rtl/mse_out_if.sv */
// Interface of the result channel: one sorted word per handshake.
`timescale 1ns / 1ps

interface mse_out_if import mse_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     end_of_set;

  modport source (output valid, output sorted_value, output end_of_set, input ready);
  modport sink (input valid, input sorted_value, input end_of_set, output ready);
endinterface

/* hw/rtl/merge_sort_engine.sv */
// Top level of the merge sort engine: microcode sequencer plus sorting datapath.
`timescale 1ns / 1ps

// The engine collects up to MAX_ELEMS signed 32-bit words, one per cycle, into
// its element store; words offered once the store is full are accepted and
// dropped. The word flagged is_last closes the set, and the engine then sorts
// it ascending with a bottom-up merge sort, ping-ponging between the element
// store and a scratch store of equal size while the run length doubles each
// pass. A pass has a setup and an end step, and each block of two runs has a
// setup and a next-block step around its merge. The pace is set by the single
// write port of each store: the merge writes one word per cycle. After
// sorting, the words leave in ascending order, one per cycle while the
// consumer is ready, with end_of_set on the last one; once the last word moves
// into the output register the engine is free for the next set. The input is
// not ready while a set is being sorted or read out, and the result sits in an
// output register, so a slow consumer only stretches the read-out phase. The
// stores power up undefined and need no clearing; only words of the current
// set are ever read.
module merge_sort_engine import mse_pkg::*; #(
  parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  mse_in_if.sink    in_ch,
  mse_out_if.source out_ch
);

  ctrl_t  ctrl;
  flags_t flags;

  // The sequencer steps through the control store and branches on the
  // datapath flags; every control word drives one datapath operation.
  mse_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  mse_dp #(
    .MAX_ELEMS (MAX_ELEMS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .flags      (flags),
    .in_valid   (in_ch.valid),
    .in_value   (in_ch.value),
    .in_is_last (in_ch.is_last),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_value  (out_ch.sorted_value),
    .out_last   (out_ch.end_of_set)
  );

  // Input is ready only on the load step of the program.
  assign in_ch.ready = ctrl.in_ready;

endmodule

/* hw/rtl/mse_ram.sv */
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module mse_ram import mse_pkg::*; #(
  parameter int WIDTH  = DATA_W,
  parameter int DEPTH  = MAX_ELEMS_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* hw/rtl/mse_seq.sv */
// Microcode sequencer: program counter, control store lookup and branch logic.
`timescale 1ns / 1ps

module mse_seq import mse_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output ctrl_t  ctrl
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            take;

  assign ctrl = mse_ucode(pc_r);

  always_comb begin
    case (ctrl.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_LAST_IN:  take = flags.last_in;
      C_SORTED:   take = flags.sorted;
      C_BLK_END:  take = flags.blk_end;
      C_MORE_BLK: take = flags.more_blk;
      C_OUT_END:  take = flags.out_end;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      pc_nxt = ctrl.tgt;
    end else if (ctrl.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* hw/rtl/mse_dp.sv */
// Datapath: element and scratch stores, merge pointers and the output register.
`timescale 1ns / 1ps
`include "merge_sort_engine_macros.svh"

module mse_dp import mse_pkg::*; #(
  parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctrl_t                    ctrl,
  output flags_t                   flags,
  input  logic                     in_valid,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_is_last,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_last
);

  localparam int IW = $clog2(MAX_ELEMS + 1);
  localparam int AW = $clog2(MAX_ELEMS);
  localparam int CW = IW + 2;

  logic [IW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] run_r, run_nxt;
  logic [IW-1:0] base_r, base_nxt;
  logic          ping_r, ping_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IW-1:0] ie_r, ie_nxt, je_r, je_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_last_r;

  logic [DATA_W-1:0]        rd_a_e, rd_b_e, rd_a_s, rd_b_s;
  logic signed [DATA_W-1:0] src_a, src_b, merge_val;

  logic [CW-1:0] n_ext, base_ext, run2, sum_run, sum_two;
  logic [IW-1:0] ie_calc, je_calc;
  logic          accept, cnt_full, a_ok, b_ok, take_a, out_load, out_last_now;

  logic              we_e, we_s;
  logic [AW-1:0]     waddr_e;
  logic [DATA_W-1:0] wdata_e;
  logic [CW-1:0]     pos_out, pos_in;

  // The ping bit selects which store holds the current source runs.
  assign src_a = ping_r ? rd_a_s : rd_a_e;
  assign src_b = ping_r ? rd_b_s : rd_b_e;

  assign n_ext    = CW'(cnt_r);
  assign base_ext = CW'(base_r);
  assign run2     = {run_r[CW-2:0], 1'b0};
  assign sum_run  = base_ext + run_r;
  assign sum_two  = base_ext + run2;
  assign ie_calc  = (sum_run < n_ext) ? sum_run[IW-1:0] : cnt_r;
  assign je_calc  = (sum_two < n_ext) ? sum_two[IW-1:0] : cnt_r;

  assign accept   = in_valid && ctrl.in_ready;
  assign cnt_full = (cnt_r == IW'(MAX_ELEMS));

  // A ties goes to the second run; an exhausted run never wins.
  assign a_ok      = (i_r < ie_r);
  assign b_ok      = (j_r < je_r);
  assign take_a    = a_ok && (!b_ok || (src_a < src_b));
  assign merge_val = take_a ? src_a : src_b;

  assign out_load     = (ctrl.op == OP_OUT) && (!out_valid_r || out_ready);
  assign out_last_now = ((i_r + IW'(1)) == cnt_r);

  assign flags.last_in  = accept && in_is_last;
  assign flags.sorted   = (run_r >= n_ext);
  assign flags.blk_end  = ((k_r + IW'(1)) == je_r);
  assign flags.more_blk = (sum_two < n_ext);
  assign flags.out_end  = out_load && out_last_now;

  always_comb begin
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    base_nxt = base_r;
    ping_nxt = ping_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    k_nxt    = k_r;
    ie_nxt   = ie_r;
    je_nxt   = je_r;
    case (ctrl.op)
      OP_LOAD: begin
        if (accept && !cnt_full) begin
          cnt_nxt = cnt_r + IW'(1);
        end
      end
      OP_START: begin
        run_nxt  = CW'(1);
        ping_nxt = 1'b0;
      end
      OP_PASS: begin
        base_nxt = '0;
      end
      OP_BLK: begin
        i_nxt  = base_r;
        j_nxt  = ie_calc;
        k_nxt  = base_r;
        ie_nxt = ie_calc;
        je_nxt = je_calc;
      end
      OP_MRG: begin
        if (take_a) begin
          i_nxt = i_r + IW'(1);
        end else begin
          j_nxt = j_r + IW'(1);
        end
        k_nxt = k_r + IW'(1);
      end
      OP_NEXTB: begin
        base_nxt = sum_two[IW-1:0];
      end
      OP_PEND: begin
        run_nxt  = run2;
        ping_nxt = !ping_r;
      end
      OP_OSET: begin
        i_nxt = '0;
      end
      OP_OUT: begin
        if (out_load) begin
          i_nxt = i_r + IW'(1);
          if (out_last_now) begin
            cnt_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Store write ports. Loads go to the element store; merges go to whichever
  // store is not the source of the current pass.
  assign we_e    = ((ctrl.op == OP_LOAD) && accept && !cnt_full)
                || ((ctrl.op == OP_MRG) && ping_r);
  assign waddr_e = (ctrl.op == OP_LOAD) ? cnt_r[AW-1:0] : k_r[AW-1:0];
  assign wdata_e = (ctrl.op == OP_LOAD) ? in_value : merge_val;
  assign we_s    = (ctrl.op == OP_MRG) && !ping_r;

  // Read addresses follow the next pointer values, so the registered read
  // data always shows the heads at the current pointers.
  mse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ELEMS)
  ) u_elem (
    .clk     (clk),
    .we      (we_e),
    .waddr   (waddr_e),
    .wdata   (wdata_e),
    .raddr_a (i_nxt[AW-1:0]),
    .raddr_b (j_nxt[AW-1:0]),
    .rdata_a (rd_a_e),
    .rdata_b (rd_b_e)
  );

  mse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ELEMS)
  ) u_scr (
    .clk     (clk),
    .we      (we_s),
    .waddr   (k_r[AW-1:0]),
    .wdata   (merge_val),
    .raddr_a (i_nxt[AW-1:0]),
    .raddr_b (j_nxt[AW-1:0]),
    .rdata_a (rd_a_s),
    .rdata_b (rd_b_s)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r  <= run_nxt;
    base_r <= base_nxt;
    ping_r <= ping_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    ie_r   <= ie_nxt;
    je_r   <= je_nxt;
    if (out_load) begin
      out_value_r <= src_a;
      out_last_r  <= out_last_now;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  // Words written so far in a block equal words consumed from both runs.
  assign pos_out = CW'(k_r) + CW'(ie_r);
  assign pos_in  = CW'(i_r) + CW'(j_r);

  `MSE_ASSERT_IMPL(a_mrg_in_block, ctrl.op == OP_MRG, k_r < je_r, "merge write past block end")
  `MSE_ASSERT_IMPL(a_mrg_balance, ctrl.op == OP_MRG, pos_out == pos_in, "merge lost or repeated a word")
  `MSE_ASSERT_IMPL(a_mrg_source, ctrl.op == OP_MRG, a_ok || b_ok, "merge step with both runs empty")
  `MSE_ASSERT_NEXT(a_set_cleared, flags.out_end, cnt_r == '0, "count not cleared after final word")

endmodule
